// ===== rtl/qmf_pkg.sv =====
// shared widths, codes and the divider stage record for the quad mesh face lookup
// no dependencies
package qmf_pkg;

  localparam int unsigned FaceW    = 22;
  localparam int unsigned CellW    = 20;
  localparam int unsigned RegW     = 11;
  localparam int unsigned MaxCells = 1024;

  // configuration register indexes
  localparam logic CFG_ACROSS = 1'b0;
  localparam logic CFG_DOWN   = 1'b1;

  typedef enum logic [2:0] {
    KIND_INNER_H = 3'd0,
    KIND_INNER_V = 3'd1,
    KIND_BOTTOM  = 3'd2,
    KIND_TOP     = 3'd3,
    KIND_LEFT    = 3'd4,
    KIND_RIGHT   = 3'd5
  } face_kind_e;

  // what one divider cell hands to the next
  typedef struct packed {
    logic             valid;
    logic [FaceW-1:0] rem;
    logic [FaceW-1:0] quot;
  } div_stage_t;

endpackage

// ===== rtl/qmf_div_cell.sv =====
// one restoring-division cell: settles a single quotient bit of face / (2*across+1)
// depends on qmf_pkg
module qmf_div_cell #(
  parameter int unsigned BIT  = 0,
  parameter int unsigned DIVW = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [DIVW-1:0]     divisor_i,
  input  qmf_pkg::div_stage_t stage_i,
  output qmf_pkg::div_stage_t stage_o
);
  import qmf_pkg::*;

  localparam int unsigned SumW = FaceW + DIVW;

  logic [SumW-1:0]  rem_ext;
  logic [SumW-1:0]  hi;
  logic [SumW-1:0]  sub;
  logic             fits;
  div_stage_t       stage_d;
  logic             valid_q;
  logic [FaceW-1:0] rem_q;
  logic [FaceW-1:0] quot_q;

  always_comb begin
    rem_ext = SumW'(stage_i.rem);
    hi      = rem_ext >> BIT;
    fits    = hi >= SumW'(divisor_i);
    sub     = rem_ext - (SumW'(divisor_i) << BIT);
    stage_d = stage_i;
    if (fits) begin
      stage_d.rem       = FaceW'(sub);
      stage_d.quot[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= stage_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= stage_d.rem;
      quot_q <= stage_d.quot;
    end
  end

  assign stage_o = '{valid: valid_q, rem: rem_q, quot: quot_q};

endmodule

// ===== rtl/qmf_classify.sv =====
// turns row and position into cell numbers and face kind, two register stages
// depends on qmf_pkg
module qmf_classify #(
  parameter int unsigned CNTW = 11
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic [CNTW-1:0]          across_i,
  input  logic [CNTW-1:0]          down_i,
  input  qmf_pkg::div_stage_t      stage_i,
  output logic                     valid_o,
  output logic [qmf_pkg::CellW-1:0] back_cell_o,
  output logic [qmf_pkg::CellW-1:0] front_cell_o,
  output logic                     front_present_o,
  output logic [2:0]               face_kind_o,
  output logic                     out_of_range_o
);
  import qmf_pkg::*;

  localparam int unsigned KW = CNTW + 1;

  logic [KW-1:0]         k;
  logic [FaceW+CNTW-1:0] prod_full;
  logic                  in_rows;
  logic                  is_top;

  logic [CellW-1:0] prod_d, back_col_d, front_col_d;
  logic             present_d, oor_d;
  face_kind_e       kind_d;

  logic             a_valid_q;
  logic [CellW-1:0] prod_q, back_col_q, front_col_q;
  logic             present_q, oor_q;
  face_kind_e       kind_q;

  logic             b_valid_q;
  logic [CellW-1:0] back_q, front_q;
  logic             b_present_q, b_oor_q;
  face_kind_e       b_kind_q;

  always_comb begin
    k         = KW'(stage_i.rem);
    prod_full = stage_i.quot * across_i;
    prod_d    = CellW'(prod_full);
    in_rows   = stage_i.quot < FaceW'(down_i);
    is_top    = (stage_i.quot == FaceW'(down_i)) && (k < KW'(across_i));

    back_col_d  = '0;
    front_col_d = '0;
    present_d   = 1'b0;
    oor_d       = 1'b0;
    kind_d      = KIND_INNER_H;

    if (in_rows) begin
      if (k == {across_i, 1'b0}) begin
        back_col_d = CellW'(across_i) - CellW'(1);
        kind_d     = KIND_RIGHT;
      end else if (k == KW'(1)) begin
        kind_d = KIND_LEFT;
      end else if (!k[0]) begin
        back_col_d = CellW'(k >> 1);
        if (stage_i.quot != '0) begin
          // lower neighbor sits one row back
          front_col_d = CellW'(k >> 1) - CellW'(across_i);
          present_d   = 1'b1;
          kind_d      = KIND_INNER_H;
        end else begin
          kind_d = KIND_BOTTOM;
        end
      end else begin
        back_col_d  = CellW'(k >> 1) - CellW'(1);
        front_col_d = CellW'(k >> 1);
        present_d   = 1'b1;
        kind_d      = KIND_INNER_V;
      end
    end else if (is_top) begin
      // row equals down here, so step back one row
      back_col_d = CellW'(k) - CellW'(across_i);
      kind_d     = KIND_TOP;
    end else begin
      oor_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= stage_i.valid;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q      <= prod_d;
      back_col_q  <= back_col_d;
      front_col_q <= front_col_d;
      present_q   <= present_d;
      oor_q       <= oor_d;
      kind_q      <= kind_d;

      back_q      <= oor_q ? '0 : prod_q + back_col_q;
      front_q     <= present_q ? prod_q + front_col_q : '0;
      b_present_q <= present_q;
      b_oor_q     <= oor_q;
      b_kind_q    <= kind_q;
    end
  end

  assign valid_o         = b_valid_q;
  assign back_cell_o     = back_q;
  assign front_cell_o    = front_q;
  assign front_present_o = b_present_q;
  assign face_kind_o     = b_kind_q;
  assign out_of_range_o  = b_oor_q;

endmodule

// ===== rtl/quad_mesh_face_to_cells.sv =====
// top level of the quad mesh face-to-cells lookup
// depends on qmf_pkg, qmf_div_cell and qmf_classify
//
// Takes one face number per cycle and returns one result per face number, in order.
// The row is found by a chain of 22 division cells, one quotient bit each, followed
// by two classify stages, all of them registered. An item that waits in the input skid
// register enters the chain once the stall clears. Sustained rate is one item per clock
// as long as results are taken; an output stall freezes the whole chain, and the skid
// register still takes one further item. Cell counts of zero act as one and counts
// above MAX_CELLS_PER_SIDE act as that maximum. Write configuration only while no
// item is in flight.
module quad_mesh_face_to_cells #(
  parameter int unsigned MAX_CELLS_PER_SIDE = qmf_pkg::MaxCells
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [qmf_pkg::RegW-1:0]   cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [qmf_pkg::FaceW-1:0]  face_number_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [qmf_pkg::CellW-1:0]  back_cell_o,
  output logic [qmf_pkg::CellW-1:0]  front_cell_o,
  output logic                       front_present_o,
  output logic [2:0]                 face_kind_o,
  output logic                       out_of_range_o
);
  import qmf_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_CELLS_PER_SIDE + 1);
  localparam int unsigned DivW = CntW + 1;

  logic [RegW-1:0] across_q, down_q;
  logic [CntW-1:0] across_eff, down_eff;
  logic [DivW-1:0] width_row;

  logic             en;
  logic             skid_valid_q;
  logic [FaceW-1:0] skid_face_q;
  div_stage_t       chain [FaceW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      across_q <= RegW'(1);
      down_q   <= RegW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ACROSS: across_q <= cfg_data_i;
        CFG_DOWN:   down_q   <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  always_comb begin
    if (across_q == '0) begin
      across_eff = CntW'(1);
    end else if (32'(across_q) > MAX_CELLS_PER_SIDE) begin
      across_eff = CntW'(MAX_CELLS_PER_SIDE);
    end else begin
      across_eff = CntW'(across_q);
    end
    if (down_q == '0) begin
      down_eff = CntW'(1);
    end else if (32'(down_q) > MAX_CELLS_PER_SIDE) begin
      down_eff = CntW'(MAX_CELLS_PER_SIDE);
    end else begin
      down_eff = CntW'(down_q);
    end
    width_row = {across_eff, 1'b1};
  end

  // the whole chain moves when the output register is free
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q && en) begin
      skid_valid_q <= 1'b0;
    end else if (!skid_valid_q && in_valid_i && !en) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_valid_q && in_valid_i && !en) begin
      skid_face_q <= face_number_i;
    end
  end

  assign chain[0].valid = skid_valid_q || in_valid_i;
  assign chain[0].rem   = skid_valid_q ? skid_face_q : face_number_i;
  assign chain[0].quot  = '0;

  for (genvar j = 0; j < FaceW; j++) begin : g_cell
    qmf_div_cell #(
      .BIT  (FaceW - 1 - j),
      .DIVW (DivW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .divisor_i (width_row),
      .stage_i   (chain[j]),
      .stage_o   (chain[j+1])
    );
  end

  qmf_classify #(
    .CNTW (CntW)
  ) u_classify (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (en),
    .across_i        (across_eff),
    .down_i          (down_eff),
    .stage_i         (chain[FaceW]),
    .valid_o         (out_valid_o),
    .back_cell_o     (back_cell_o),
    .front_cell_o    (front_cell_o),
    .front_present_o (front_present_o),
    .face_kind_o     (face_kind_o),
    .out_of_range_o  (out_of_range_o)
  );

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for quad_mesh_face_to_cells: face lookups on many mesh sizes
// depends on qmf_pkg and the quad_mesh_face_to_cells rtl; results are checked in order
// against a behavioral lookup kept in this file
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import qmf_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 30;
  localparam int unsigned LongHold = 200;

  typedef struct packed {
    logic [CellW-1:0] back;
    logic [CellW-1:0] front;
    logic             present;
    face_kind_e       kind;
    logic             oor;
  } face_cells_t;

  typedef enum logic {RX_OPEN, RX_CHOPPY} rx_mode_e;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic             cfg_index_i;
  logic [RegW-1:0]  cfg_data_i;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [FaceW-1:0] face_number_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [CellW-1:0] back_cell_o;
  logic [CellW-1:0] front_cell_o;
  logic             front_present_o;
  logic [2:0]       face_kind_o;
  logic             out_of_range_o;

  // shadow copy of the mesh registers
  logic [RegW-1:0] across_q = 1;
  logic [RegW-1:0] down_q = 1;

  face_cells_t pending_cells[$];
  int unsigned mismatch_count = 0;
  rx_mode_e    rx_mode = RX_OPEN;
  bit          hold_request = 1'b0;

  quad_mesh_face_to_cells u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .face_number_i   (face_number_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .back_cell_o     (back_cell_o),
    .front_cell_o    (front_cell_o),
    .front_present_o (front_present_o),
    .face_kind_o     (face_kind_o),
    .out_of_range_o  (out_of_range_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("status: fail");
    $finish;
  end

  function automatic int unsigned clamp_count(logic [RegW-1:0] v);
    if (v == 0) return 1;
    if (v > MaxCells) return MaxCells;
    return v;
  endfunction

  function automatic face_cells_t lookup_face(logic [FaceW-1:0] face);
    face_cells_t res;
    int unsigned a, d, w, row, k;
    a = clamp_count(across_q);
    d = clamp_count(down_q);
    w = 2 * a + 1;
    row = face / w;
    k = face - row * w;
    res = '0;
    res.kind = KIND_INNER_H;
    if (row < d) begin
      if (k == 2 * a) begin
        res.back = CellW'(row * a + (a - 1));
        res.kind = KIND_RIGHT;
      end else if (k == 1) begin
        res.back = CellW'(row * a);
        res.kind = KIND_LEFT;
      end else if (k % 2 == 0) begin
        res.back = CellW'(row * a + k / 2);
        if (row > 0) begin
          res.front = CellW'((row - 1) * a + k / 2);
          res.present = 1'b1;
          res.kind = KIND_INNER_H;
        end else begin
          res.kind = KIND_BOTTOM;
        end
      end else begin
        res.back = CellW'(row * a + (k - 1) / 2 - 1);
        res.front = CellW'(row * a + (k - 1) / 2);
        res.present = 1'b1;
        res.kind = KIND_INNER_V;
      end
    end else if (row == d && k < a) begin
      res.back = CellW'((d - 1) * a + k);
      res.kind = KIND_TOP;
    end else begin
      res.oor = 1'b1;
    end
    return res;
  endfunction

  // mostly faces inside the mesh, with edges and out-of-range noise mixed in
  function automatic logic [FaceW-1:0] pick_face();
    int unsigned a, d, w, total, row, k;
    a = clamp_count(across_q);
    d = clamp_count(down_q);
    w = 2 * a + 1;
    total = d * w + a;
    case ($urandom_range(0, 9))
      0: return FaceW'($urandom());
      1: return FaceW'(total + $urandom_range(0, 3));
      2: return FaceW'(total - 1 - $urandom_range(0, 3));
      3, 4: begin
        row = $urandom_range(0, d - 1);
        case ($urandom_range(0, 3))
          0: k = 0;
          1: k = 1;
          2: k = 2 * a;
          default: k = 2 * a - 1;
        endcase
        return FaceW'(row * w + k);
      end
      default: return FaceW'($urandom_range(0, total - 1));
    endcase
  endfunction

  // expectation is taken when the item is accepted
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) pending_cells.push_back(lookup_face(face_number_i));
  end

  always @(posedge clk_i) begin
    face_cells_t exp;
    if (out_valid_o && out_ready_i) begin
      if (pending_cells.size() == 0) begin
        $error("result with no item outstanding");
        mismatch_count++;
      end else begin
        exp = pending_cells.pop_front();
        if (back_cell_o !== exp.back) begin
          $error("back_cell expected %0d got %0d", exp.back, back_cell_o);
          mismatch_count++;
        end
        if (front_cell_o !== exp.front) begin
          $error("front_cell expected %0d got %0d", exp.front, front_cell_o);
          mismatch_count++;
        end
        if (front_present_o !== exp.present) begin
          $error("front_present expected %0d got %0d", exp.present, front_present_o);
          mismatch_count++;
        end
        if (face_kind_o !== exp.kind) begin
          $error("face_kind expected %0d got %0d", exp.kind, face_kind_o);
          mismatch_count++;
        end
        if (out_of_range_o !== exp.oor) begin
          $error("out_of_range expected %0d got %0d", exp.oor, out_of_range_o);
          mismatch_count++;
        end
      end
    end
  end

  // receiver: open, or alternating ready and stall runs, plus an occasional long hold
  initial begin
    int  run;
    bit  cur;
    run = 0;
    cur = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LongHold) @(negedge clk_i);
      end
      if (rx_mode == RX_OPEN) begin
        out_ready_i <= 1'b1;
      end else begin
        if (run == 0) begin
          cur = ~cur;
          run = cur ? $urandom_range(1, 40) : $urandom_range(1, 8);
        end
        run--;
        out_ready_i <= cur;
      end
    end
  end

  task automatic send_face(input logic [FaceW-1:0] face);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    face_number_i <= face;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic idle_input(input int unsigned n);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // only called with nothing in flight
  task automatic set_mesh(input logic [RegW-1:0] a, input logic [RegW-1:0] d);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_ACROSS;
    cfg_data_i <= a;
    across_q = a;
    @(negedge clk_i);
    cfg_index_i <= CFG_DOWN;
    cfg_data_i <= d;
    down_q = d;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // 1x1 mesh straight out of reset
  task automatic test_reset_values();
    send_face(0);
    send_face(2);
    send_face(3);
    send_face(4);
    drain_results();
  endtask

  // 3x2 mesh: every face kind, first and last top faces, first face past the end
  task automatic test_small_mesh();
    set_mesh(3, 2);
    send_face(0);
    send_face(1);
    send_face(2);
    send_face(3);
    send_face(6);
    send_face(7);
    send_face(8);
    send_face(10);
    send_face(14);
    send_face(16);
    send_face(17);
    send_face({FaceW{1'b1}});
    drain_results();
  endtask

  // zero counts act as one, counts above the maximum act as the maximum
  task automatic test_clamped_counts();
    set_mesh(0, 0);
    send_face(1);
    send_face(3);
    send_face(4);
    drain_results();
    set_mesh({RegW{1'b1}}, {RegW{1'b1}});
    send_face(2099199);
    send_face(2099200);
    send_face({FaceW{1'b1}});
    drain_results();
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    set_mesh(16, 16);
    rx_mode = RX_OPEN;
    hold_request = 1'b1;
    repeat (80) send_face(pick_face());
    drain_results();
  endtask

  task automatic test_random_meshes();
    int unsigned across_set[8];
    int unsigned down_set[8];
    int unsigned burst;
    across_set = '{1, 1024, 0, 2047, 1, 1024, 0, 0};
    down_set   = '{1, 1024, 2047, 0, 1024, 1, 0, 0};
    across_set[6] = $urandom_range(1, 1024);
    down_set[6]   = $urandom_range(1, 1024);
    across_set[7] = $urandom_range(0, 2047);
    down_set[7]   = $urandom_range(0, 2047);
    for (int s = 0; s < 8; s++) begin
      set_mesh(RegW'(across_set[s]), RegW'(down_set[s]));
      rx_mode = (s == 0) ? RX_OPEN : RX_CHOPPY;
      burst = $urandom_range(1, 30);
      for (int i = 0; i < 44; i++) begin
        send_face(pick_face());
        // in the fourth mesh only, the sender waits for every result once mid-phase
        if (s == 3 && i == 22) drain_results();
        if (burst == 0) begin
          idle_input($urandom_range(1, 12));
          burst = $urandom_range(1, 30);
        end else begin
          burst--;
        end
      end
      drain_results();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_ACROSS;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    face_number_i = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_small_mesh();
    test_clamped_counts();
    test_backpressure();
    test_random_meshes();

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
